// ===== src/btpc_pkg.sv =====
// shared types, constants and helpers for the barometric compensation block
`default_nettype none
package btpc_pkg;

    localparam int PADDR_W    = 6;
    localparam int PDATA_W    = 64;
    localparam int DIV_STAGES = 32;
    localparam int SIDE_W     = 64;

    // register indexes, taken from paddr[5:3]
    localparam logic [2:0] REG_OSS     = 3'd0;
    localparam logic [2:0] REG_CAL_A_S = 3'd1;
    localparam logic [2:0] REG_CAL_A_U = 3'd2;
    localparam logic [2:0] REG_CAL_B   = 3'd3;
    localparam logic [2:0] REG_CAL_M   = 3'd4;

    localparam logic [31:0] C_T_OFFSET = 32'd4000;
    localparam logic [31:0] C_B4_BIAS  = 32'd32768;
    localparam logic [31:0] C_B7_SCALE = 32'd50000;
    localparam logic [31:0] C_MSB      = 32'h8000_0000;
    localparam logic [31:0] C_P_K1     = 32'd3038;
    localparam logic [31:0] C_P_K2     = -32'sd7357;
    localparam logic [31:0] C_P_K3     = 32'd3791;
    localparam logic [31:0] C_T_MAX    = 32'sd8191;
    localparam logic [31:0] C_T_MIN    = -32'sd8192;
    localparam logic [31:0] C_P_MAX    = 32'd1048575;

    typedef struct packed {
        logic [1:0]  oss;
        logic [47:0] cal_a_signed;
        logic [47:0] cal_a_unsigned;
        logic [31:0] cal_b_pair;
        logic [31:0] cal_m_pair;
    } cfg_t;

    // sideband carried alongside the temperature divider
    typedef struct packed {
        logic [5:0]  pad;
        logic [31:0] x1;
        logic [23:0] up;
        logic        qneg;
        logic        dzero;
    } side1_t;

    // sideband carried alongside the pressure divider
    typedef struct packed {
        logic [46:0] pad;
        logic [13:0] t_sat;
        logic        err;
        logic        b7hi;
        logic        b4zero;
    } side2_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
        return 32'($signed(v) >>> n);
    endfunction

endpackage
`default_nettype wire

// ===== src/btpc_regs.sv =====
// configuration register file behind the apb port
`default_nettype none
module btpc_regs
    import btpc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[5:3];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_OSS:     cfg_reg.oss            <= pwdata[1:0];
                REG_CAL_A_S: cfg_reg.cal_a_signed   <= pwdata[47:0];
                REG_CAL_A_U: cfg_reg.cal_a_unsigned <= pwdata[47:0];
                REG_CAL_B:   cfg_reg.cal_b_pair     <= pwdata[31:0];
                REG_CAL_M:   cfg_reg.cal_m_pair     <= pwdata[31:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_OSS:     prdata = {62'd0, cfg_reg.oss};
            REG_CAL_A_S: prdata = {16'd0, cfg_reg.cal_a_signed};
            REG_CAL_A_U: prdata = {16'd0, cfg_reg.cal_a_unsigned};
            REG_CAL_B:   prdata = {32'd0, cfg_reg.cal_b_pair};
            REG_CAL_M:   prdata = {32'd0, cfg_reg.cal_m_pair};
            default:     prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== src/btpc_div.sv =====
// pipelined 32-bit unsigned restoring divider, one quotient bit per stage
`default_nettype none
module btpc_div
    import btpc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [31:0]       dividend,
    input  wire logic [31:0]       divisor,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic      [31:0]       quotient,
    output logic      [SIDE_W-1:0] side_out
);

    logic [DIV_STAGES-1:0] vld_reg;
    logic [31:0]           rem_reg  [DIV_STAGES];
    logic [31:0]           work_reg [DIV_STAGES];
    logic [31:0]           den_reg  [DIV_STAGES];
    logic [SIDE_W-1:0]     side_reg [DIV_STAGES];

    logic [31:0] src_rem  [DIV_STAGES];
    logic [31:0] src_work [DIV_STAGES];
    logic [31:0] src_den  [DIV_STAGES];
    logic [31:0] rem_next  [DIV_STAGES];
    logic [31:0] work_next [DIV_STAGES];

    always_comb
    begin
        src_rem[0]  = '0;
        src_work[0] = dividend;
        src_den[0]  = divisor;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            src_rem[k]  = rem_reg[k-1];
            src_work[k] = work_reg[k-1];
            src_den[k]  = den_reg[k-1];
        end
    end

    // shift in the next dividend bit, subtract when it fits
    always_comb
    begin
        logic [32:0] trial;
        logic        qbit;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            trial = {src_rem[k], src_work[k][31]};
            if (trial >= {1'b0, src_den[k]})
            begin
                rem_next[k] = 32'(trial - {1'b0, src_den[k]});
                qbit        = 1'b1;
            end
            else
            begin
                rem_next[k] = trial[31:0];
                qbit        = 1'b0;
            end
            work_next[k] = {src_work[k][30:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                work_reg[k] <= work_next[k];
                den_reg[k]  <= src_den[k];
            end
            side_reg[0] <= side_in;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign quotient  = work_reg[DIV_STAGES-1];
    assign side_out  = side_reg[DIV_STAGES-1];

`ifndef ASSERT_OFF
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[DIV_STAGES-1] && den_reg[DIV_STAGES-1] != 32'd0)
            |-> rem_reg[DIV_STAGES-1] < den_reg[DIV_STAGES-1])
        else $error("divider remainder not below divisor");
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("divider valid bits moved during a stall");
    a_den_carried: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[0]) |=> den_reg[1] == $past(den_reg[0]))
        else $error("divisor lost between divider stages");
`endif

endmodule
`default_nettype wire

// ===== src/baro_temp_pressure_compensate.sv =====
// top level: barometric temperature and pressure compensation pipeline
//
//  channel   dir  width  contents
//  s_axis    in   40     tdata: raw_temp [15:0], raw_press [39:16]
//  m_axis    out  40     tdata: temp_tenths [13:0], press_pa [33:14]; tuser: div_error
//  apb       in   64     oversampling, cal_a_signed, cal_a_unsigned, cal_b_pair, cal_m_pair
//
//  one sample enters per cycle unless m_axis back-pressure stalls the pipeline; it consists of the
//  two 32-stage dividers plus eleven arithmetic stages around them
//  reset clears all valid bits and the calibration registers
//  the whole pipeline holds while a result waits on m_axis_tready; nothing is dropped
`default_nettype none
module baro_temp_pressure_compensate
    import btpc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [39:0]        s_axis_tdata,   // raw_temp, raw_press
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic      [39:0]        m_axis_tdata,   // temp_tenths, press_pa
    output logic                    m_axis_tuser,   // div_error
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    cfg_t        cfg;
    logic        adv;
    logic [1:0]  oss;
    logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

    btpc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign oss = cfg.oss;
    assign ac1 = cfg.cal_a_signed[47:32];
    assign ac2 = cfg.cal_a_signed[31:16];
    assign ac3 = cfg.cal_a_signed[15:0];
    assign ac4 = cfg.cal_a_unsigned[47:32];
    assign ac5 = cfg.cal_a_unsigned[31:16];
    assign ac6 = cfg.cal_a_unsigned[15:0];
    assign b1  = cfg.cal_b_pair[31:16];
    assign b2  = cfg.cal_b_pair[15:0];
    assign mc  = cfg.cal_m_pair[31:16];
    assign md  = cfg.cal_m_pair[15:0];

    logic o_vld_reg;
    assign adv           = !o_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // ---- t1: (ut - ac6) * ac5
    logic signed [16:0] t_diff;
    logic signed [33:0] t_prod;
    logic        [23:0] up_c;
    logic               t1_vld_reg;
    logic        [31:0] t1_prod_reg;
    logic        [23:0] t1_up_reg;

    assign t_diff = $signed({1'b0, s_axis_tdata[15:0]}) - $signed({1'b0, ac6});
    assign t_prod = 34'(t_diff) * 34'($signed({1'b0, ac5}));
    assign up_c   = s_axis_tdata[39:16] >> (4'd8 - {2'b00, oss});

    // ---- temperature divider operands
    logic [31:0] x1_c, d_c, num_c, n_abs, d_abs;
    side1_t      s1_in, s1_out;
    logic        div1_vld;
    logic [31:0] quot1;
    logic [SIDE_W-1:0] side1_raw;

    assign x1_c  = asr32(t1_prod_reg, 5'd15);
    assign d_c   = x1_c + sx16(md);
    assign num_c = {{5{mc[15]}}, mc, 11'd0};
    assign n_abs = num_c[31] ? (~num_c + 32'd1) : num_c;
    assign d_abs = d_c[31] ? (~d_c + 32'd1) : d_c;

    always_comb
    begin
        s1_in       = '0;
        s1_in.x1    = x1_c;
        s1_in.up    = t1_up_reg;
        s1_in.qneg  = num_c[31] ^ d_c[31];
        s1_in.dzero = (d_c == 32'd0);
    end

    btpc_div u_div_temp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (t1_vld_reg),
        .dividend  (n_abs),
        .divisor   (d_abs),
        .side_in   (s1_in),
        .out_valid (div1_vld),
        .quotient  (quot1),
        .side_out  (side1_raw)
    );
    assign s1_out = side1_raw;

    // ---- t3: signed quotient
    logic        t3_vld_reg;
    logic [31:0] t3_x1_reg, t3_x2_reg;
    logic [23:0] t3_up_reg;
    logic        t3_err_reg;
    logic [31:0] x2_c;

    assign x2_c = s1_out.dzero ? '1 : (s1_out.qneg ? (~quot1 + 32'd1) : quot1);

    // ---- t4: b5, temperature, b6
    logic [31:0] b5_c, tt_c;
    logic [13:0] t_sat_c;
    logic        t4_vld_reg;
    logic [31:0] t4_b6_reg;
    logic [13:0] t4_t_reg;
    logic [23:0] t4_up_reg;
    logic        t4_err_reg;

    assign b5_c = t3_x1_reg + t3_x2_reg;
    assign tt_c = asr32(b5_c + 32'd8, 5'd4);

    always_comb
    begin
        if ($signed(tt_c) > $signed(C_T_MAX))
        begin
            t_sat_c = C_T_MAX[13:0];
        end
        else if ($signed(tt_c) < $signed(C_T_MIN))
        begin
            t_sat_c = C_T_MIN[13:0];
        end
        else
        begin
            t_sat_c = tt_c[13:0];
        end
    end

    // ---- p1: b6 products
    logic        p1_vld_reg;
    logic [31:0] p1_sq_reg, p1_x2a_reg, p1_x1b_reg;
    logic [13:0] p1_t_reg;
    logic [23:0] p1_up_reg;
    logic        p1_err_reg;
    logic [31:0] sq_c, ac2b6_c, ac3b6_c;

    assign sq_c    = t4_b6_reg * t4_b6_reg;
    assign ac2b6_c = sx16(ac2) * t4_b6_reg;
    assign ac3b6_c = sx16(ac3) * t4_b6_reg;

    // ---- p2: b1, b2 terms
    logic        p2_vld_reg;
    logic [31:0] p2_m1_reg, p2_m2_reg, p2_x2a_reg, p2_x1b_reg;
    logic [13:0] p2_t_reg;
    logic [23:0] p2_up_reg;
    logic        p2_err_reg;
    logic [31:0] m1_c, m2_c;

    assign m1_c = sx16(b2) * p1_sq_reg;
    assign m2_c = sx16(b1) * p1_sq_reg;

    // ---- p3: b3 and x3
    logic        p3_vld_reg;
    logic [31:0] p3_b3_reg, p3_x3b_reg;
    logic [13:0] p3_t_reg;
    logic [23:0] p3_up_reg;
    logic        p3_err_reg;
    logic [31:0] x3a_c, b3s_c, b3_c, x3b_c;

    assign x3a_c = p2_m1_reg + p2_x2a_reg;
    assign b3s_c = ((sx16(ac1) << 2) + x3a_c) << oss;
    assign b3_c  = asr32(b3s_c + 32'd2, 5'd2);
    assign x3b_c = asr32(p2_x1b_reg + p2_m2_reg + 32'd2, 5'd2);

    // ---- p4: b4 and b7
    logic        p4_vld_reg;
    logic [31:0] p4_b4_reg, p4_b7_reg;
    logic [13:0] p4_t_reg;
    logic        p4_err_reg;
    logic [31:0] b4p_c, b7_c;

    assign b4p_c = {16'd0, ac4} * (p3_x3b_reg + C_B4_BIAS);
    assign b7_c  = ({8'd0, p3_up_reg} - p3_b3_reg) * (C_B7_SCALE >> oss);

    // ---- pressure divider
    side2_t      s2_in, s2_out;
    logic        div2_vld;
    logic [31:0] quot2, num2_c;
    logic [SIDE_W-1:0] side2_raw;
    logic        b7hi_c;

    assign b7hi_c = (p4_b7_reg >= C_MSB);
    assign num2_c = b7hi_c ? p4_b7_reg : {p4_b7_reg[30:0], 1'b0};

    always_comb
    begin
        s2_in        = '0;
        s2_in.t_sat  = p4_t_reg;
        s2_in.err    = p4_err_reg;
        s2_in.b7hi   = b7hi_c;
        s2_in.b4zero = (p4_b4_reg == 32'd0);
    end

    btpc_div u_div_press (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p4_vld_reg),
        .dividend  (num2_c),
        .divisor   (p4_b4_reg),
        .side_in   (s2_in),
        .out_valid (div2_vld),
        .quotient  (quot2),
        .side_out  (side2_raw)
    );
    assign s2_out = side2_raw;

    // ---- q1: raw pressure
    logic        q1_vld_reg;
    logic [31:0] q1_p_reg;
    logic [13:0] q1_t_reg;
    logic        q1_err_reg;
    logic [31:0] pu_c;

    always_comb
    begin
        if (s2_out.b4zero)
        begin
            pu_c = s2_out.b7hi ? 32'hFFFF_FFFE : 32'hFFFF_FFFF;
        end
        else if (s2_out.b7hi)
        begin
            pu_c = {quot2[30:0], 1'b0};
        end
        else
        begin
            pu_c = quot2;
        end
    end

    // ---- q2: square and linear term
    logic        q2_vld_reg;
    logic [31:0] q2_sq_reg, q2_x2_reg, q2_p_reg;
    logic [13:0] q2_t_reg;
    logic        q2_err_reg;
    logic [31:0] p8_c, psq_c, px2_c;

    assign p8_c  = asr32(q1_p_reg, 5'd8);
    assign psq_c = p8_c * p8_c;
    assign px2_c = C_P_K2 * q1_p_reg;

    // ---- q3: scaled square
    logic        q3_vld_reg;
    logic [31:0] q3_x1_reg, q3_x2_reg, q3_p_reg;
    logic [13:0] q3_t_reg;
    logic        q3_err_reg;
    logic [31:0] px1_c;

    assign px1_c = q2_sq_reg * C_P_K1;

    // ---- output: final pressure with saturation
    logic [31:0] pf_c;
    logic [19:0] p_sat_c;
    logic [13:0] o_t_reg;
    logic [19:0] o_p_reg;
    logic        o_err_reg;

    assign pf_c = q3_p_reg + asr32(q3_x1_reg + q3_x2_reg + C_P_K3, 5'd4);

    always_comb
    begin
        if (pf_c[31])
        begin
            p_sat_c = '0;
        end
        else if (pf_c > C_P_MAX)
        begin
            p_sat_c = C_P_MAX[19:0];
        end
        else
        begin
            p_sat_c = pf_c[19:0];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_vld_reg <= 1'b0;
            t3_vld_reg <= 1'b0;
            t4_vld_reg <= 1'b0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            p4_vld_reg <= 1'b0;
            q1_vld_reg <= 1'b0;
            q2_vld_reg <= 1'b0;
            q3_vld_reg <= 1'b0;
            o_vld_reg  <= 1'b0;
        end
        else if (adv)
        begin
            t1_vld_reg <= s_axis_tvalid;
            t3_vld_reg <= div1_vld;
            t4_vld_reg <= t3_vld_reg;
            p1_vld_reg <= t4_vld_reg;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            p4_vld_reg <= p3_vld_reg;
            q1_vld_reg <= div2_vld;
            q2_vld_reg <= q1_vld_reg;
            q3_vld_reg <= q2_vld_reg;
            o_vld_reg  <= q3_vld_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_prod_reg <= t_prod[31:0];
            t1_up_reg   <= up_c;

            t3_x1_reg   <= s1_out.x1;
            t3_x2_reg   <= x2_c;
            t3_up_reg   <= s1_out.up;
            t3_err_reg  <= s1_out.dzero;

            t4_b6_reg   <= b5_c - C_T_OFFSET;
            t4_t_reg    <= t_sat_c;
            t4_up_reg   <= t3_up_reg;
            t4_err_reg  <= t3_err_reg;

            p1_sq_reg   <= asr32(sq_c, 5'd12);
            p1_x2a_reg  <= asr32(ac2b6_c, 5'd11);
            p1_x1b_reg  <= asr32(ac3b6_c, 5'd13);
            p1_t_reg    <= t4_t_reg;
            p1_up_reg   <= t4_up_reg;
            p1_err_reg  <= t4_err_reg;

            p2_m1_reg   <= asr32(m1_c, 5'd11);
            p2_m2_reg   <= asr32(m2_c, 5'd16);
            p2_x2a_reg  <= p1_x2a_reg;
            p2_x1b_reg  <= p1_x1b_reg;
            p2_t_reg    <= p1_t_reg;
            p2_up_reg   <= p1_up_reg;
            p2_err_reg  <= p1_err_reg;

            p3_b3_reg   <= b3_c;
            p3_x3b_reg  <= x3b_c;
            p3_t_reg    <= p2_t_reg;
            p3_up_reg   <= p2_up_reg;
            p3_err_reg  <= p2_err_reg;

            p4_b4_reg   <= b4p_c >> 15;
            p4_b7_reg   <= b7_c;
            p4_t_reg    <= p3_t_reg;
            p4_err_reg  <= p3_err_reg;

            q1_p_reg    <= pu_c;
            q1_t_reg    <= s2_out.t_sat;
            q1_err_reg  <= s2_out.err | s2_out.b4zero;

            q2_sq_reg   <= psq_c;
            q2_x2_reg   <= asr32(px2_c, 5'd16);
            q2_p_reg    <= q1_p_reg;
            q2_t_reg    <= q1_t_reg;
            q2_err_reg  <= q1_err_reg;

            q3_x1_reg   <= asr32(px1_c, 5'd16);
            q3_x2_reg   <= q2_x2_reg;
            q3_p_reg    <= q2_p_reg;
            q3_t_reg    <= q2_t_reg;
            q3_err_reg  <= q2_err_reg;

            o_t_reg     <= q3_t_reg;
            o_p_reg     <= p_sat_c;
            o_err_reg   <= q3_err_reg;
        end
    end

    assign m_axis_tvalid = o_vld_reg;
    assign m_axis_tdata  = {6'd0, o_p_reg, o_t_reg};
    assign m_axis_tuser  = o_err_reg;

endmodule
`default_nettype wire

// ===== tb/sv/tb_baro_temp_pressure_compensate.sv =====
// self-checking testbench for the barometric temperature and pressure compensation block
`timescale 1ns / 100ps
`default_nettype none
module tb_baro_temp_pressure_compensate;
    import btpc_pkg::*;

    localparam int LATENCY   = 75;
    localparam int MAX_CYCLE = 400000;

    typedef struct packed {
        logic [23:0] raw_press;
        logic [15:0] raw_temp;
    } sample_t;

    typedef struct packed {
        logic [13:0] temp_tenths;
        logic [19:0] press_pa;
        logic        div_error;
    } reading_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic m_axis_tuser;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    baro_temp_pressure_compensate dut (.*);

    always #6 clk = ~clk;

    // predictor copy of the calibration
    logic [1:0]  oss_set;
    logic [47:0] cal_as, cal_au;
    logic [31:0] cal_b, cal_m;

    sample_t  pending_samples[$];
    reading_t expected_readings[$];
    int  errors = 0;
    int  checked = 0;
    int  cycle = 0;
    bit  steady = 1'b0;
    int  hold_off = 0;

    function automatic logic signed [31:0] s16(input logic [15:0] v);
        return $signed(v);
    endfunction

    function automatic reading_t compensate(input sample_t s);
        logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md, ut, up;
        logic signed [31:0] x1, x2, x3, d, b3, b5, b6, t, p, sq;
        logic [31:0] ac4, ac5, ac6, b4, b7, pu;
        logic err;
        reading_t r;
        ac1 = s16(cal_as[47:32]); ac2 = s16(cal_as[31:16]); ac3 = s16(cal_as[15:0]);
        ac4 = {16'd0, cal_au[47:32]}; ac5 = {16'd0, cal_au[31:16]};
        ac6 = {16'd0, cal_au[15:0]};
        b1 = s16(cal_b[31:16]); b2 = s16(cal_b[15:0]);
        mc = s16(cal_m[31:16]); md = s16(cal_m[15:0]);
        ut = {16'd0, s.raw_temp};
        up = {8'd0, s.raw_press} >> (4'd8 - oss_set);
        err = 1'b0;
        x1 = ((ut - $signed(ac6)) * $signed(ac5)) >>> 15;
        d = x1 + md;
        if (d == 0)
        begin
            x2 = -1;
            err = 1'b1;
        end
        else
            x2 = (mc <<< 11) / d;
        b5 = x1 + x2;
        t = (b5 + 8) >>> 4;
        b6 = b5 - 4000;
        sq = (b6 * b6) >>> 12;
        x1 = (b2 * sq) >>> 11;
        x2 = (ac2 * b6) >>> 11;
        x3 = x1 + x2;
        b3 = (((ac1 * 4 + x3) <<< oss_set) + 2) >>> 2;
        x1 = (ac3 * b6) >>> 13;
        x2 = (b1 * sq) >>> 16;
        x3 = (x1 + x2 + 2) >>> 2;
        b4 = (ac4 * 32'(x3 + 32768)) >> 15;
        b7 = 32'(up - b3) * (32'd50000 >> oss_set);
        if (b4 == 0)
        begin
            err = 1'b1;
            pu = (b7 < 32'h8000_0000) ? 32'hFFFF_FFFF : 32'hFFFF_FFFE;
        end
        else if (b7 < 32'h8000_0000)
            pu = (b7 << 1) / b4;
        else
            pu = (b7 / b4) << 1;
        p = $signed(pu);
        x1 = (p >>> 8) * (p >>> 8);
        x1 = (x1 * 3038) >>> 16;
        x2 = (-7357 * p) >>> 16;
        p = p + ((x1 + x2 + 3791) >>> 4);
        if (t > 8191) t = 8191;
        if (t < -8192) t = -8192;
        if (p < 0) p = 0;
        if (p > 1048575) p = 1048575;
        r.temp_tenths = t[13:0];
        r.press_pa = p[19:0];
        r.div_error = err;
        return r;
    endfunction

    // sender
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_readings.push_back(compensate(sample_t'(s_axis_tdata)));
            if ((!s_axis_tvalid || s_axis_tready) && pending_samples.size() > 0
                && (steady || $urandom_range(99) >= 32))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_samples.pop_front();
            end
            else if (!s_axis_tvalid || s_axis_tready)
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        reading_t got, want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[13:0], m_axis_tdata[33:14], m_axis_tuser};
                if (expected_readings.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected reading %h", $time, got);
                end
                else
                begin
                    want = expected_readings.pop_front();
                    checked++;
                    if (got.temp_tenths !== want.temp_tenths)
                    begin
                        errors++;
                        $display("%0t: temp_tenths expected %0d actual %0d", $time,
                                 $signed(want.temp_tenths), $signed(got.temp_tenths));
                    end
                    if (got.press_pa !== want.press_pa)
                    begin
                        errors++;
                        $display("%0t: press_pa expected %0d actual %0d", $time,
                                 want.press_pa, got.press_pa);
                    end
                    if (got.div_error !== want.div_error)
                    begin
                        errors++;
                        $display("%0t: div_error expected %b actual %b", $time,
                                 want.div_error, got.div_error);
                    end
                end
            end
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= steady || $urandom_range(99) >= 32;
        end
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE)
        begin
            $display("cycle limit reached, %0d readings outstanding",
                     expected_readings.size());
            $display("baro_temp_pressure_compensate regression: fail");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_OSS:     oss_set = value[1:0];
            REG_CAL_A_S: cal_as = value[47:0];
            REG_CAL_A_U: cal_au = value[47:0];
            REG_CAL_B:   cal_b = value[31:0];
            REG_CAL_M:   cal_m = value[31:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_samples.size() == 0 && !s_axis_tvalid);
        wait (expected_readings.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    task automatic load_calibration(input int mode);
        if (mode == 0)
        begin
            // typical datasheet calibration
            reg_write(REG_CAL_A_S, {16'd408, -16'sd72, -16'sd14383});
            reg_write(REG_CAL_A_U, {16'd32741, 16'd32757, 16'd23153});
            reg_write(REG_CAL_B, {16'd6190, 16'd4});
            reg_write(REG_CAL_M, {-16'sd8711, 16'd2868});
        end
        else if (mode == 1)
        begin
            reg_write(REG_CAL_A_S, {$urandom, $urandom});
            reg_write(REG_CAL_A_U, {$urandom, $urandom});
            reg_write(REG_CAL_B, $urandom);
            reg_write(REG_CAL_M, $urandom);
        end
        else if (mode == 2)
        begin
            reg_write(REG_CAL_A_S, 64'hFFFF_FFFF_FFFF_FFFF);
            reg_write(REG_CAL_A_U, 64'hFFFF_FFFF_FFFF);
            reg_write(REG_CAL_B, 64'h8000_7FFF);
            reg_write(REG_CAL_M, 64'h7FFF_8000);
        end
        else
        begin
            // the all-zero set (ac4, ac5 and md zero) forces both divisors to zero
            reg_write(REG_CAL_A_S, 64'h0);
            reg_write(REG_CAL_A_U, 64'h0);
            reg_write(REG_CAL_B, 64'h0);
            reg_write(REG_CAL_M, 64'h0);
        end
    endtask

    task automatic push_sample(input logic [15:0] t, input logic [23:0] p);
        pending_samples.push_back({p, t});
    endtask

    initial
    begin
        oss_set = 0; cal_as = 0; cal_au = 0; cal_b = 0; cal_m = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        // directed: reset calibration gives zero divisors
        push_sample(16'h0000, 24'h000000);
        push_sample(16'hFFFF, 24'hFFFFFF);
        drain();
        load_calibration(0);
        for (int o = 0; o < 4; o++)
        begin
            reg_write(REG_OSS, o);
            push_sample(16'd27898, 24'h5D23_00);
            push_sample(16'h0000, 24'h000000);
            push_sample(16'hFFFF, 24'hFFFFFF);
            push_sample(16'h8000, 24'h800000);
            push_sample(16'h7FFF, 24'h7FFFFF);
            drain();
        end
        load_calibration(2);
        push_sample(16'hFFFF, 24'hFFFFFF);
        push_sample(16'h0000, 24'h000001);
        drain();
        // random phases over several calibrations and oversampling settings
        for (int ph = 0; ph < 12; ph++)
        begin
            reg_write(REG_OSS, (ph == 0) ? 3 : $urandom_range(3));
            load_calibration(ph == 11 ? 3 : (ph % 3 == 0 ? 0 : (ph == 5 ? 2 : 1)));
            steady = (ph == 4);
            if (ph == 2)
                hold_off = 300;
            for (int i = 0; i < 75; i++)
            begin
                if (ph % 3 == 0)
                    push_sample(16'(20000 + $urandom_range(15000)), 24'($urandom));
                else
                    push_sample(rnd16(), 24'($urandom));
            end
            drain();
        end
        $display("covered %0d readings across four oversampling settings", checked);
        $display("calibration: typical, random, extreme and zero-divisor sets");
        if (errors == 0)
            $display("baro_temp_pressure_compensate regression: pass");
        else
            $display("baro_temp_pressure_compensate regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
